[rtl/psfp_pkg.sv]
package psfp_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 8;
    localparam int LEN_W  = WORD_W + 1;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4D;

    localparam logic [BYTE_W-1:0] MAX_FRAME_RESET = 8'd80;

    // Byte positions inside a frame, counted from 1.
    localparam logic [CNT_W-1:0] POS_LEN_END  = 8'd4;
    localparam logic [CNT_W-1:0] POS_PM1_STD  = 8'd6;
    localparam logic [CNT_W-1:0] POS_PM25_STD = 8'd8;
    localparam logic [CNT_W-1:0] POS_PM10_STD = 8'd10;
    localparam logic [CNT_W-1:0] POS_PM1_AMB  = 8'd12;
    localparam logic [CNT_W-1:0] POS_PM25_AMB = 8'd14;
    localparam logic [CNT_W-1:0] POS_PM10_AMB = 8'd16;
    localparam logic [CNT_W-1:0] POS_TEMP     = 8'd26;
    localparam logic [CNT_W-1:0] POS_HUMID    = 8'd28;
    localparam logic [CNT_W-1:0] POS_VERSION  = 8'd29;
    localparam logic [CNT_W-1:0] POS_ERROR    = 8'd30;
    localparam logic [CNT_W-1:0] POS_SUM_LAST = 8'd30;
    localparam logic [CNT_W-1:0] POS_CHECKSUM = 8'd32;

    localparam logic [LEN_W-1:0] LEN_OVERHEAD = 17'd4;

    localparam int NUM_WORDS = 8;

    typedef struct packed {
        logic [WORD_W-1:0] pm1_standard;
        logic [WORD_W-1:0] pm25_standard;
        logic [WORD_W-1:0] pm10_standard;
        logic [WORD_W-1:0] pm1_ambient;
        logic [WORD_W-1:0] pm25_ambient;
        logic [WORD_W-1:0] pm10_ambient;
        logic [WORD_W-1:0] temperature_raw;
        logic [WORD_W-1:0] humidity_raw;
        logic [BYTE_W-1:0] version_byte;
        logic [BYTE_W-1:0] error_byte;
        logic              checksum_ok;
    } t_result;

endpackage

[rtl/psfp_in_if.sv]
interface psfp_in_if;
    import psfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/psfp_out_if.sv]
interface psfp_out_if;
    import psfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pm1_standard;
    logic [WORD_W-1:0] pm25_standard;
    logic [WORD_W-1:0] pm10_standard;
    logic [WORD_W-1:0] pm1_ambient;
    logic [WORD_W-1:0] pm25_ambient;
    logic [WORD_W-1:0] pm10_ambient;
    logic [WORD_W-1:0] temperature_raw;
    logic [WORD_W-1:0] humidity_raw;
    logic [BYTE_W-1:0] version_byte;
    logic [BYTE_W-1:0] error_byte;
    logic              checksum_ok;

    modport source (
        output valid, output pm1_standard, output pm25_standard, output pm10_standard,
        output pm1_ambient, output pm25_ambient, output pm10_ambient,
        output temperature_raw, output humidity_raw, output version_byte,
        output error_byte, output checksum_ok, input ready
    );
    modport sink (
        input valid, input pm1_standard, input pm25_standard, input pm10_standard,
        input pm1_ambient, input pm25_ambient, input pm10_ambient,
        input temperature_raw, input humidity_raw, input version_byte,
        input error_byte, input checksum_ok, output ready
    );
endinterface

[rtl/particle_sensor_frame_parser_top.sv]
// Channel   Direction  Handshake         Word carried
// i_rx      in         valid / ready     rx_byte, one received serial byte
// o_res     out        valid / ready     one parsed frame record per frame
// i_cfg_*   in         write enable      max_frame_bytes, no read-back
//
// One word is accepted per cycle while i_rx.ready is high. Its whole effect on
// the parser state is computed in the cycle it is accepted, and a finished frame
// record is registered into the output register; while that one is held, the
// record parks in a skid register, so i_rx.ready drops only while both are full.
// Reset is synchronous and active low; it restores hunting and the 80-byte cap.
module particle_sensor_frame_parser_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [psfp_pkg::BYTE_W-1:0] i_cfg_wdata,
    psfp_in_if.sink                i_rx,
    psfp_out_if.source             o_res
);
    import psfp_pkg::*;

    // Configuration register: the frame length cap.
    logic [BYTE_W-1:0] r_max_frame;

    // Parser state.
    logic              r_in_frame,  n_in_frame;
    logic [CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [CNT_W-1:0]  r_frame_end, n_frame_end;
    logic [BYTE_W-1:0] r_prev_byte, n_prev_byte;
    logic [WORD_W-1:0] r_running_sum, n_running_sum;
    logic [WORD_W-1:0] r_words [NUM_WORDS];
    logic [WORD_W-1:0] n_words [NUM_WORDS];
    logic [BYTE_W-1:0] r_version, n_version;
    logic [BYTE_W-1:0] r_error, n_error;
    logic              r_cks_match, n_cks_match;

    // Output register and the skid register behind it.
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic              accept;
    logic              frame_done;
    logic              pop;
    logic [BYTE_W-1:0] rx_b;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt_inc;
    logic [LEN_W-1:0]  frame_len;
    t_result           new_result;

    // Ready depends only on the skid register, never on the incoming byte.
    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid && i_rx.ready;
    assign pop        = r_out_valid && o_res.ready;
    assign rx_b       = i_rx.rx_byte;
    assign word       = {r_prev_byte, rx_b};
    assign cnt_inc    = r_byte_count + 8'd1;
    assign frame_len  = {1'b0, word} + LEN_OVERHEAD;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_byte_count  = r_byte_count;
        n_frame_end   = r_frame_end;
        n_prev_byte   = r_prev_byte;
        n_running_sum = r_running_sum;
        n_words       = r_words;
        n_version     = r_version;
        n_error       = r_error;
        n_cks_match   = r_cks_match;
        frame_done    = 1'b0;

        if (accept) begin
            n_prev_byte = rx_b;
            if (!r_in_frame) begin
                // Hunting for the header. A wrong second byte restarts the hunt,
                // and a repeated first header byte is taken as a fresh start.
                if (r_byte_count == 8'd1 && rx_b == HDR_SECOND) begin
                    n_running_sum = r_running_sum + {8'd0, rx_b};
                    n_byte_count  = 8'd2;
                    n_in_frame    = 1'b1;
                end else if (rx_b == HDR_FIRST) begin
                    n_byte_count  = 8'd1;
                    n_running_sum = {8'd0, rx_b};
                    n_cks_match   = 1'b0;
                end else begin
                    n_byte_count = 8'd0;
                end
            end else begin
                n_byte_count = cnt_inc;
                if (cnt_inc <= POS_SUM_LAST) begin
                    n_running_sum = r_running_sum + {8'd0, rx_b};
                end
                unique case (cnt_inc)
                    POS_LEN_END: begin
                        // The declared length excludes the header and itself.
                        if (frame_len > {9'd0, r_max_frame}) begin
                            n_frame_end = r_max_frame;
                        end else begin
                            n_frame_end = frame_len[CNT_W-1:0];
                        end
                    end
                    POS_PM1_STD:  n_words[0] = word;
                    POS_PM25_STD: n_words[1] = word;
                    POS_PM10_STD: n_words[2] = word;
                    POS_PM1_AMB:  n_words[3] = word;
                    POS_PM25_AMB: n_words[4] = word;
                    POS_PM10_AMB: n_words[5] = word;
                    POS_TEMP:     n_words[6] = word;
                    POS_HUMID:    n_words[7] = word;
                    POS_VERSION:  n_version  = rx_b;
                    POS_ERROR:    n_error    = rx_b;
                    POS_CHECKSUM: n_cks_match = (r_running_sum == word);
                    default: begin
                    end
                endcase
                // The end test uses the frame end just computed, so a frame can
                // close on the byte that carries its length.
                if (cnt_inc >= n_frame_end) begin
                    frame_done   = 1'b1;
                    n_byte_count = 8'd0;
                    n_in_frame   = 1'b0;
                end
            end
        end
    end

    always_comb begin
        new_result.pm1_standard    = n_words[0];
        new_result.pm25_standard   = n_words[1];
        new_result.pm10_standard   = n_words[2];
        new_result.pm1_ambient     = n_words[3];
        new_result.pm25_ambient    = n_words[4];
        new_result.pm10_ambient    = n_words[5];
        new_result.temperature_raw = n_words[6];
        new_result.humidity_raw    = n_words[7];
        new_result.version_byte    = n_version;
        new_result.error_byte      = n_error;
        new_result.checksum_ok     = n_cks_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame   <= MAX_FRAME_RESET;
            r_in_frame    <= 1'b0;
            r_byte_count  <= '0;
            r_frame_end   <= MAX_FRAME_RESET;
            r_prev_byte   <= '0;
            r_running_sum <= '0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_words[k] <= '0;
            end
            r_version     <= '0;
            r_error       <= '0;
            r_cks_match   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_frame <= i_cfg_wdata;
            end
            r_in_frame    <= n_in_frame;
            r_byte_count  <= n_byte_count;
            r_frame_end   <= n_frame_end;
            r_prev_byte   <= n_prev_byte;
            r_running_sum <= n_running_sum;
            r_words       <= n_words;
            r_version     <= n_version;
            r_error       <= n_error;
            r_cks_match   <= n_cks_match;
        end
    end

    // The skid register fills only when the output register is held, and it
    // drains into the output register before any new record can be accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= frame_done;
                end
            end else if (frame_done) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : new_result;
        end else if (frame_done) begin
            r_skid <= new_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.pm1_standard    = r_out.pm1_standard;
    assign o_res.pm25_standard   = r_out.pm25_standard;
    assign o_res.pm10_standard   = r_out.pm10_standard;
    assign o_res.pm1_ambient     = r_out.pm1_ambient;
    assign o_res.pm25_ambient    = r_out.pm25_ambient;
    assign o_res.pm10_ambient    = r_out.pm10_ambient;
    assign o_res.temperature_raw = r_out.temperature_raw;
    assign o_res.humidity_raw    = r_out.humidity_raw;
    assign o_res.version_byte    = r_out.version_byte;
    assign o_res.error_byte      = r_out.error_byte;
    assign o_res.checksum_ok     = r_out.checksum_ok;

    // A parked record always sits behind a record in the output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a record while the output register is empty");

    // Inside a frame both header bytes have been counted.
    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_byte_count >= 8'd2))
        else $error("byte count below two inside a frame");

    // While hunting, at most the first header byte has been seen.
    a_hunt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_count <= 8'd1))
        else $error("byte count above one while hunting");

    // A record is only produced by a byte that arrives inside a frame.
    a_done_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_done |-> (accept && r_in_frame))
        else $error("frame end raised outside a frame");

endmodule
